>>> hw/rtl/crm_pkg.sv
// ----------------------------------------------------------------------------
// crm_pkg
// Shared constants and helper functions for the command/response matcher with retry.
// ----------------------------------------------------------------------------
package crm_pkg;

    // pattern geometry
    localparam int unsigned MAX_PATTERN_BYTES = 8;
    localparam int unsigned PATTERN_W         = 64;
    localparam int unsigned INDEX_W           = 4;

    // timeout
    localparam int unsigned TICK_W         = 10;
    localparam int unsigned UNIT_W         = 11;
    localparam int unsigned TICKS_PER_UNIT = 1000;
    localparam int unsigned TIMEOUT_UNITS  = 2000;

    localparam int unsigned ATTEMPT_W = 8;

    // input modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_A     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_A      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_B     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_B      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTEMPT_LIMIT = 3'd4;

    // register reset values
    localparam logic [INDEX_W-1:0]   LENGTH_RESET        = 4'd1;
    localparam logic [ATTEMPT_W-1:0] ATTEMPT_LIMIT_RESET = 8'd3;

    // length 0 counts as 1, lengths above the maximum are clamped
    function automatic logic [INDEX_W-1:0] eff_len(input logic [INDEX_W-1:0] len);
        logic [INDEX_W-1:0] res;
        res = len;
        if (len == '0) begin
            res = INDEX_W'(1);
        end else if (len > INDEX_W'(MAX_PATTERN_BYTES)) begin
            res = INDEX_W'(MAX_PATTERN_BYTES);
        end
        return res;
    endfunction

    // naive match step: advance on equal byte, else drop to zero
    function automatic logic [INDEX_W-1:0] advance(
        input logic [INDEX_W-1:0]   idx,
        input logic [PATTERN_W-1:0] pat,
        input logic [7:0]           b
    );
        logic [INDEX_W-1:0] res;
        res = '0;
        if (idx < INDEX_W'(MAX_PATTERN_BYTES)) begin
            if (pat[idx[2:0]*8 +: 8] == b) begin
                res = idx + INDEX_W'(1);
            end
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/command_response_matcher_retry.sv
// ----------------------------------------------------------------------------
// command_response_matcher_retry
// Issues a command and waits for a success or alternate reply, with retry.
//
// Input channel (i_in_valid / o_in_stall) carries a mode and a received byte:
// start an exchange, one received byte, or one timer tick. Every accepted
// transfer yields exactly one result transfer on the output channel
// (o_out_valid / i_out_stall): send_command, finished, outcome, last_failure
// and attempts_remaining.
// Each transfer passes through the input register, then the matcher and timer
// update into the result register. Throughput is one item per cycle while the
// receiver does not stall; the exchange state loop has no extra register in it.
// When the receiver stalls, the result register holds and the input register
// fills; o_in_stall rises only when both are occupied.
// Configuration is written through i_cfg_valid / o_cfg_ready (always ready)
// and is meant to change only while no item is in flight.
// Reset (synchronous, active low) empties both registers, clears the exchange
// state and loads the register reset values. No clearing pass is needed.
// ----------------------------------------------------------------------------
module command_response_matcher_retry (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_mode,
    input  logic [7:0]                           i_rx_byte,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_send_command,
    output logic                                 o_finished,
    output logic                                 o_outcome,
    output logic                                 o_last_failure,
    output logic [crm_pkg::ATTEMPT_W-1:0]        o_attempts_remaining,
    // configuration
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [crm_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [crm_pkg::PATTERN_W-1:0]        i_cfg_data
);

    localparam int unsigned IW = crm_pkg::INDEX_W;
    localparam int unsigned TW = crm_pkg::TICK_W;
    localparam int unsigned UW = crm_pkg::UNIT_W;
    localparam int unsigned AW = crm_pkg::ATTEMPT_W;

    // configuration registers
    logic [crm_pkg::PATTERN_W-1:0] r_pattern_a;
    logic [crm_pkg::PATTERN_W-1:0] r_pattern_b;
    logic [IW-1:0]                 r_length_a;
    logic [IW-1:0]                 r_length_b;
    logic [AW-1:0]                 r_attempt_limit;

    // input register
    logic       r_in_valid;
    logic [1:0] r_mode;
    logic [7:0] r_rx_byte;

    // exchange state
    logic          r_busy,          n_busy;
    logic [IW-1:0] r_match_index_a, n_match_index_a;
    logic [IW-1:0] r_match_index_b, n_match_index_b;
    logic [TW-1:0] r_tick_count,    n_tick_count;
    logic [UW-1:0] r_units_left,    n_units_left;
    logic [AW-1:0] r_attempts_left, n_attempts_left;
    logic          r_failure_kind,  n_failure_kind;

    // result register
    logic r_out_valid;
    logic r_send_command, n_send_command;
    logic r_finished,     n_finished;
    logic r_outcome,      n_outcome;

    logic          in_take;
    logic          out_load;
    logic          fail_attempt;
    logic [IW-1:0] adv_a;
    logic [IW-1:0] adv_b;
    logic [TW-1:0] tick_inc;
    logic [UW-1:0] units_dec;
    logic [AW-1:0] attempts_dec;

    assign o_cfg_ready = 1'b1;
    assign out_load    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && r_out_valid && i_out_stall;
    assign in_take     = i_in_valid && !o_in_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_a     <= '0;
            r_pattern_b     <= '0;
            r_length_a      <= crm_pkg::LENGTH_RESET;
            r_length_b      <= crm_pkg::LENGTH_RESET;
            r_attempt_limit <= crm_pkg::ATTEMPT_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                crm_pkg::CFG_PATTERN_A:     r_pattern_a     <= i_cfg_data;
                crm_pkg::CFG_LENGTH_A:      r_length_a      <= i_cfg_data[IW-1:0];
                crm_pkg::CFG_PATTERN_B:     r_pattern_b     <= i_cfg_data;
                crm_pkg::CFG_LENGTH_B:      r_length_b      <= i_cfg_data[IW-1:0];
                crm_pkg::CFG_ATTEMPT_LIMIT: r_attempt_limit <= i_cfg_data[AW-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mode    <= i_mode;
            r_rx_byte <= i_rx_byte;
        end
    end

    assign adv_a        = crm_pkg::advance(r_match_index_a, r_pattern_a, r_rx_byte);
    assign adv_b        = crm_pkg::advance(r_match_index_b, r_pattern_b, r_rx_byte);
    assign tick_inc     = r_tick_count + TW'(1);
    assign units_dec    = r_units_left - UW'(1);
    assign attempts_dec = r_attempts_left - AW'(1);

    // matcher, timer and retry update
    always_comb begin
        n_busy          = r_busy;
        n_match_index_a = r_match_index_a;
        n_match_index_b = r_match_index_b;
        n_tick_count    = r_tick_count;
        n_units_left    = r_units_left;
        n_attempts_left = r_attempts_left;
        n_failure_kind  = r_failure_kind;
        n_send_command  = 1'b0;
        n_finished      = 1'b0;
        n_outcome       = 1'b0;
        fail_attempt    = 1'b0;

        case (r_mode)
            crm_pkg::MODE_START: begin
                n_busy          = 1'b1;
                n_attempts_left = r_attempt_limit;
                n_failure_kind  = 1'b0;
                n_match_index_a = '0;
                n_match_index_b = '0;
                n_tick_count    = '0;
                n_units_left    = UW'(crm_pkg::TIMEOUT_UNITS);
                n_send_command  = 1'b1;
            end
            crm_pkg::MODE_BYTE: begin
                if (r_busy) begin
                    n_match_index_a = adv_a;
                    n_match_index_b = adv_b;
                    if (adv_a >= crm_pkg::eff_len(r_length_a)) begin
                        n_busy     = 1'b0;
                        n_finished = 1'b1;
                    end else if (adv_b >= crm_pkg::eff_len(r_length_b)) begin
                        n_failure_kind = 1'b0;
                        fail_attempt   = 1'b1;
                    end
                end
            end
            crm_pkg::MODE_TICK: begin
                if (r_busy) begin
                    n_tick_count = tick_inc;
                    if (tick_inc >= TW'(crm_pkg::TICKS_PER_UNIT)) begin
                        n_tick_count = '0;
                        n_units_left = units_dec;
                        if (units_dec == '0) begin
                            n_failure_kind = 1'b1;
                            fail_attempt   = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase

        if (fail_attempt) begin
            n_attempts_left = attempts_dec;
            if (attempts_dec == '0) begin
                n_busy     = 1'b0;
                n_finished = 1'b1;
                n_outcome  = 1'b1;
            end else begin
                n_match_index_a = '0;
                n_match_index_b = '0;
                n_tick_count    = '0;
                n_units_left    = UW'(crm_pkg::TIMEOUT_UNITS);
                n_send_command  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b0;
            r_match_index_a <= '0;
            r_match_index_b <= '0;
            r_tick_count    <= '0;
            r_units_left    <= UW'(crm_pkg::TIMEOUT_UNITS);
            r_attempts_left <= '0;
            r_failure_kind  <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (out_load) begin
                r_busy          <= n_busy;
                r_match_index_a <= n_match_index_a;
                r_match_index_b <= n_match_index_b;
                r_tick_count    <= n_tick_count;
                r_units_left    <= n_units_left;
                r_attempts_left <= n_attempts_left;
                r_failure_kind  <= n_failure_kind;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_send_command <= n_send_command;
            r_finished     <= n_finished;
            r_outcome      <= n_outcome;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_send_command       = r_send_command;
    assign o_finished           = r_finished;
    assign o_outcome            = r_outcome;
    assign o_last_failure       = r_failure_kind;
    assign o_attempts_remaining = r_attempts_left;

endmodule

>>> hw/rtl/crm_checker.sv
// ----------------------------------------------------------------------------
// crm_checker
// Port-level checks for the command/response matcher, bound to the top level.
// ----------------------------------------------------------------------------
module crm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_send_command,
    input logic                          o_finished,
    input logic                          o_outcome,
    input logic                          o_last_failure,
    input logic [crm_pkg::ATTEMPT_W-1:0] o_attempts_remaining
);

    // a result either asks for a command or ends the exchange, never both
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_send_command && o_finished))
        else $error("send_command and finished together");

    // failure outcome only on a finishing transfer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_outcome) |-> o_finished)
        else $error("outcome set without finished");

    // exhausted budget reports zero attempts left
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_outcome) |-> (o_attempts_remaining == '0))
        else $error("exhausted with attempts remaining");

    // stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_send_command)
            && $stable(o_finished) && $stable(o_outcome) && $stable(o_last_failure)
            && $stable(o_attempts_remaining)))
        else $error("stalled result changed");

    // no result right after reset
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind command_response_matcher_retry crm_checker u_crm_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_out_valid          (o_out_valid),
    .i_out_stall          (i_out_stall),
    .o_send_command       (o_send_command),
    .o_finished           (o_finished),
    .o_outcome            (o_outcome),
    .o_last_failure       (o_last_failure),
    .o_attempts_remaining (o_attempts_remaining)
);
